// ----- sv/nkm_pkg.sv -----
// Shared constants and register codes for the keyword matcher.
// No dependencies; every other file refers to this package by scoped names.
`default_nettype none

package nkm_pkg;

    localparam int MAX_KEY_LEN  = 16;
    localparam int OFFSET_BITS  = 32;
    localparam int KEY_LEN_W    = 5;
    localparam int BYTE_W       = 8;
    localparam int COUNT_W      = 32;
    localparam int MATCH_OFF_W  = 32;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 64;
    localparam int KEY_WORD_BYTES = CFG_DATA_W / BYTE_W;
    localparam int WIN_IDX_W    = (MAX_KEY_LEN > 1) ? $clog2(MAX_KEY_LEN) : 1;

    localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = {OFFSET_BITS{1'b1}};
    localparam logic [COUNT_W-1:0]     COUNT_MAX  = {COUNT_W{1'b1}};
    localparam logic [KEY_LEN_W-1:0]   KEY_LEN_MAX = KEY_LEN_W'(MAX_KEY_LEN);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KEY_LENGTH     = 2'd0,
        REG_KEY_BYTES_LOW  = 2'd1,
        REG_KEY_BYTES_HIGH = 2'd2
    } cfg_reg_t;

endpackage : nkm_pkg

`default_nettype wire

// ----- sv/nkm_stream_if.sv -----
// Valid/ready channels for the keyword matcher: file bytes in, matches out.
// Depends on nkm_pkg for field widths.
`default_nettype none

interface nkm_in_if;
    logic                       valid;
    logic                       ready;
    logic [nkm_pkg::BYTE_W-1:0] data_byte;
    logic                       start_of_file;

    modport source (output valid, output data_byte, output start_of_file, input ready);
    modport sink   (input valid, input data_byte, input start_of_file, output ready);
endinterface : nkm_in_if

interface nkm_out_if;
    logic                            valid;
    logic                            ready;
    logic [nkm_pkg::COUNT_W-1:0]     match_number;
    logic [nkm_pkg::MATCH_OFF_W-1:0] match_offset;

    modport source (output valid, output match_number, output match_offset, input ready);
    modport sink   (input valid, input match_number, input match_offset, output ready);
endinterface : nkm_out_if

`default_nettype wire

// ----- sv/nonoverlap_keyword_matcher.sv -----
// Non-overlapping keyword matcher: input register, window compare, result register.
// Depends on nkm_pkg and the channel interfaces in nkm_stream_if.sv.
//
// Usage:
//   bytes   : one file byte per item, start_of_file set on the first byte of a
//             file (clears window, offset, match count and holdoff).
//   hits    : one item per keyword hit: running match number and the 0-based
//             offset of the first keyword byte. Bytes that end no match give
//             no item.
//   cfg_*   : write port for key_length (index 0), key bytes 0..7 (index 1)
//             and key bytes 8..15 (index 2); write only while idle.
// Path: the last byte of a hit is compared in the input register, and the hit
//   is then registered in the result register; a full result register holds
//   the byte in the input register until it can take the hit.
// Throughput: one byte per cycle unless a hit waits in the input register;
//   window shift, 16-byte compare and offset/count update fit between registers.
// Stall: while hits is stalled the result register holds; bytes that give
//   no hit keep flowing, and a second hit waits in the input register.
// Reset: key_length 1, key bytes zero, window and counters cleared; the
//   stream counts as one file from reset until a start_of_file arrives.
`default_nettype none

module nonoverlap_keyword_matcher (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [nkm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [nkm_pkg::CFG_DATA_W-1:0]   cfg_data,
    nkm_in_if.sink                                bytes,
    nkm_out_if.source                             hits
);

    // configuration
    logic [nkm_pkg::KEY_LEN_W-1:0]  key_len_reg;
    logic [nkm_pkg::CFG_DATA_W-1:0] key_low_reg;
    logic [nkm_pkg::CFG_DATA_W-1:0] key_high_reg;

    // input register
    logic                           s1_valid_reg;
    logic [nkm_pkg::BYTE_W-1:0]     s1_byte_reg;
    logic                           s1_sof_reg;

    // per-file state
    logic [nkm_pkg::BYTE_W-1:0]     win_reg [nkm_pkg::MAX_KEY_LEN];
    logic [nkm_pkg::OFFSET_BITS-1:0] seen_reg;
    logic [nkm_pkg::KEY_LEN_W-1:0]  holdoff_reg;
    logic [nkm_pkg::COUNT_W-1:0]    count_reg;

    // result register
    logic                           out_valid_reg;
    logic [nkm_pkg::COUNT_W-1:0]    out_number_reg;
    logic [nkm_pkg::MATCH_OFF_W-1:0] out_offset_reg;

    // combinational
    logic [nkm_pkg::BYTE_W-1:0]     win_next [nkm_pkg::MAX_KEY_LEN];
    logic [nkm_pkg::BYTE_W-1:0]     key_byte [nkm_pkg::MAX_KEY_LEN];
    logic [nkm_pkg::KEY_LEN_W-1:0]  len_eff;
    logic [nkm_pkg::KEY_LEN_W-1:0]  len_m1;
    logic [nkm_pkg::OFFSET_BITS-1:0] pos;
    logic [nkm_pkg::OFFSET_BITS-1:0] seen_next;
    logic [nkm_pkg::OFFSET_BITS-1:0] start_pos;
    logic [nkm_pkg::KEY_LEN_W-1:0]  holdoff_eff;
    logic [nkm_pkg::COUNT_W-1:0]    count_eff;
    logic [nkm_pkg::COUNT_W-1:0]    count_next;
    logic                           bytes_match;
    logic                           enough_bytes;
    logic                           hit;
    logic                           out_free;
    logic                           s1_fire;
    logic                           in_fire;

    // Key length 0 acts as 1, anything above the window depth as the depth.
    always_comb
    begin
        if (key_len_reg == '0)
        begin
            len_eff = nkm_pkg::KEY_LEN_W'(1);
        end
        else if (key_len_reg > nkm_pkg::KEY_LEN_MAX)
        begin
            len_eff = nkm_pkg::KEY_LEN_MAX;
        end
        else
        begin
            len_eff = key_len_reg;
        end
        len_m1 = len_eff - nkm_pkg::KEY_LEN_W'(1);
    end

    always_comb
    begin
        for (int i = 0; i < nkm_pkg::MAX_KEY_LEN; i++)
        begin
            if (i < nkm_pkg::KEY_WORD_BYTES)
            begin
                key_byte[i] = key_low_reg[i*nkm_pkg::BYTE_W +: nkm_pkg::BYTE_W];
            end
            else
            begin
                key_byte[i] = key_high_reg[(i - nkm_pkg::KEY_WORD_BYTES)*nkm_pkg::BYTE_W
                                           +: nkm_pkg::BYTE_W];
            end
        end
    end

    // State as seen by the byte in the input register: a start flag clears it first.
    assign pos         = s1_sof_reg ? '0 : seen_reg;
    assign holdoff_eff = s1_sof_reg ? '0 : holdoff_reg;
    assign count_eff   = s1_sof_reg ? '0 : count_reg;
    assign seen_next   = (pos == nkm_pkg::OFFSET_MAX) ? pos
                                                      : pos + nkm_pkg::OFFSET_BITS'(1);

    // Window after the shift; entry 0 holds the newest byte.
    always_comb
    begin
        for (int i = 0; i < nkm_pkg::MAX_KEY_LEN; i++)
        begin
            if (i == 0)
            begin
                win_next[i] = s1_byte_reg;
            end
            else if (s1_sof_reg)
            begin
                win_next[i] = '0;
            end
            else
            begin
                win_next[i] = win_reg[i-1];
            end
        end
    end

    // Key byte i sits at window entry len-1-i.
    always_comb
    begin
        logic [nkm_pkg::WIN_IDX_W-1:0] idx;
        bytes_match = 1'b1;
        for (int i = 0; i < nkm_pkg::MAX_KEY_LEN; i++)
        begin
            idx = nkm_pkg::WIN_IDX_W'(len_m1) - nkm_pkg::WIN_IDX_W'(i);
            if ((nkm_pkg::KEY_LEN_W'(i) < len_eff) && (win_next[idx] != key_byte[i]))
            begin
                bytes_match = 1'b0;
            end
        end
    end

    assign enough_bytes = (pos >= nkm_pkg::OFFSET_BITS'(len_m1));
    assign hit          = s1_valid_reg && (holdoff_eff == '0) && enough_bytes && bytes_match;
    assign start_pos    = pos - nkm_pkg::OFFSET_BITS'(len_m1);
    assign count_next   = (count_eff == nkm_pkg::COUNT_MAX) ? count_eff
                                                            : count_eff + nkm_pkg::COUNT_W'(1);

    // A byte leaves the input register unless it carries a hit and the result
    // register is still full.
    assign out_free     = !out_valid_reg || hits.ready;
    assign s1_fire      = s1_valid_reg && (!hit || out_free);
    assign bytes.ready  = !s1_valid_reg || s1_fire;
    assign in_fire      = bytes.valid && bytes.ready;

    assign hits.valid        = out_valid_reg;
    assign hits.match_number = out_number_reg;
    assign hits.match_offset = out_offset_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_len_reg  <= nkm_pkg::KEY_LEN_W'(1);
            key_low_reg  <= '0;
            key_high_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (nkm_pkg::cfg_reg_t'(cfg_index))
                nkm_pkg::REG_KEY_LENGTH:     key_len_reg  <= cfg_data[nkm_pkg::KEY_LEN_W-1:0];
                nkm_pkg::REG_KEY_BYTES_LOW:  key_low_reg  <= cfg_data;
                nkm_pkg::REG_KEY_BYTES_HIGH: key_high_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (bytes.ready)
        begin
            s1_valid_reg <= bytes.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_byte_reg <= bytes.data_byte;
            s1_sof_reg  <= bytes.start_of_file;
        end
    end

    // Per-file state, updated as each byte leaves the input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < nkm_pkg::MAX_KEY_LEN; i++)
            begin
                win_reg[i] <= '0;
            end
            seen_reg    <= '0;
            holdoff_reg <= '0;
            count_reg   <= '0;
        end
        else if (s1_fire)
        begin
            for (int i = 0; i < nkm_pkg::MAX_KEY_LEN; i++)
            begin
                win_reg[i] <= win_next[i];
            end
            seen_reg <= seen_next;
            if (holdoff_eff != '0)
            begin
                holdoff_reg <= holdoff_eff - nkm_pkg::KEY_LEN_W'(1);
                count_reg   <= count_eff;
            end
            else if (hit)
            begin
                holdoff_reg <= len_m1;
                count_reg   <= count_next;
            end
            else
            begin
                holdoff_reg <= '0;
                count_reg   <= count_eff;
            end
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_fire && hit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (hits.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && hit)
        begin
            out_number_reg <= count_next;
            out_offset_reg <= nkm_pkg::MATCH_OFF_W'(start_pos);
        end
    end

endmodule : nonoverlap_keyword_matcher

`default_nettype wire
